### hdl/tlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB shared definitions
// Request codes, statistic width and controller/datapath command bundle.
// ----------------------------------------------------------------------------
package tlb_pkg;

    localparam int STAT_BITS = 32;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_FLUSH  = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef struct packed {
        logic load;     // capture the accepted item
        logic exec;     // apply the captured request to the entry array
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_status;

endpackage

### hdl/tlb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB datapath
// Entry array, parallel tag compare, LRU ranks, statistics and result regs.
// ----------------------------------------------------------------------------
module tlb_datapath #(
    parameter int ENTRIES   = 16,
    parameter int VPN_BITS  = 36,
    parameter int PPN_BITS  = 28,
    parameter int ASID_BITS = 16,
    parameter int IDX_BITS  = 4,
    parameter int CNT_BITS  = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tlb_pkg::t_cmd             i_cmd,
    input  logic [1:0]                i_req,
    input  logic [VPN_BITS-1:0]       i_vpn,
    input  logic [PPN_BITS-1:0]       i_ppn,
    input  logic [ASID_BITS-1:0]      i_asid,
    output logic                      o_hit,
    output logic [PPN_BITS-1:0]       o_found,
    output logic                      o_evicted,
    output logic [IDX_BITS-1:0]       o_slot,
    output logic [tlb_pkg::STAT_BITS-1:0] o_lookups,
    output logic [tlb_pkg::STAT_BITS-1:0] o_hits,
    output logic [tlb_pkg::STAT_BITS-1:0] o_evictions,
    output logic [tlb_pkg::STAT_BITS-1:0] o_flushes,
    output logic [tlb_pkg::STAT_BITS-1:0] o_drops
);
    localparam int SB = tlb_pkg::STAT_BITS;
    localparam logic [SB-1:0] SMAX = '1;

    logic [ENTRIES-1:0]  r_valid;
    logic [VPN_BITS-1:0] r_vpn  [ENTRIES];
    logic [PPN_BITS-1:0] r_ppn  [ENTRIES];
    logic [ASID_BITS-1:0] r_asid [ENTRIES];
    logic [IDX_BITS-1:0] r_rank [ENTRIES];

    logic [1:0]           r_req;
    logic [VPN_BITS-1:0]  r_in_vpn;
    logic [PPN_BITS-1:0]  r_in_ppn;

    logic [ENTRIES-1:0]  match;
    logic                any_hit, any_free;
    logic [IDX_BITS-1:0] hit_idx, free_idx, lru_idx, tgt;
    logic [IDX_BITS:0]   old_rank;
    logic [CNT_BITS-1:0] n_valid;
    logic [SB:0]         drop_sum;

    always_comb begin
        any_hit = 1'b0; hit_idx = '0;
        any_free = 1'b0; free_idx = '0;
        lru_idx = '0; n_valid = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && r_vpn[i] == r_in_vpn && r_asid[i] == i_asid;
            n_valid = n_valid + CNT_BITS'(r_valid[i]);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                any_hit = 1'b1; hit_idx = IDX_BITS'(i);
            end
            if (!r_valid[i]) begin
                any_free = 1'b1; free_idx = IDX_BITS'(i);
            end
            // all valid: ranks are a permutation, the top rank is unique
            if (r_rank[i] == IDX_BITS'(ENTRIES - 1)) lru_idx = IDX_BITS'(i);
        end
        tgt = (r_req == tlb_pkg::REQ_LOOKUP) ? hit_idx : (any_free ? free_idx : lru_idx);
        old_rank = (r_req == tlb_pkg::REQ_INSERT && any_free) ?
                   (IDX_BITS+1)'(ENTRIES) : {1'b0, r_rank[tgt]};
        drop_sum = {1'b0, o_drops} + (SB+1)'(n_valid);
    end

    wire do_touch = (r_req == tlb_pkg::REQ_LOOKUP && any_hit) || r_req == tlb_pkg::REQ_INSERT;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_in_vpn <= i_vpn;
            r_in_ppn <= i_ppn;
        end
        if (i_cmd.exec && do_touch) begin
            for (int i = 0; i < ENTRIES; i++)
                if (IDX_BITS'(i) != tgt && r_valid[i] && {1'b0, r_rank[i]} < old_rank)
                    r_rank[i] <= r_rank[i] + 1'b1;
            r_rank[tgt] <= '0;
            if (r_req == tlb_pkg::REQ_INSERT) begin
                r_vpn[tgt]  <= r_in_vpn;
                r_ppn[tgt]  <= r_in_ppn;
                r_asid[tgt] <= i_asid;
            end
        end
        if (i_cmd.exec) begin
            o_hit     <= r_req == tlb_pkg::REQ_LOOKUP && any_hit;
            o_found   <= (r_req == tlb_pkg::REQ_LOOKUP && any_hit) ? r_ppn[tgt] : '0;
            o_evicted <= r_req == tlb_pkg::REQ_INSERT && !any_free;
            o_slot    <= do_touch ? tgt : '0;
        end
        if (!i_rst_n) begin
            r_valid <= '0;
            o_lookups <= '0; o_hits <= '0; o_evictions <= '0;
            o_flushes <= '0; o_drops <= '0;
        end else if (i_cmd.exec) begin
            unique case (r_req)
                tlb_pkg::REQ_LOOKUP: begin
                    if (o_lookups != SMAX) o_lookups <= o_lookups + 1'b1;
                    if (any_hit && o_hits != SMAX) o_hits <= o_hits + 1'b1;
                end
                tlb_pkg::REQ_INSERT: begin
                    r_valid[tgt] <= 1'b1;
                    if (!any_free && o_evictions != SMAX)
                        o_evictions <= o_evictions + 1'b1;
                end
                tlb_pkg::REQ_FLUSH: begin
                    r_valid <= '0;
                    if (o_flushes != SMAX) o_flushes <= o_flushes + 1'b1;
                    o_drops <= drop_sum[SB] ? SMAX : drop_sum[SB-1:0];
                end
                default: begin
                    r_valid <= '0;
                    o_lookups <= '0; o_hits <= '0; o_evictions <= '0;
                    o_flushes <= '0; o_drops <= '0;
                end
            endcase
        end
    end
endmodule

### hdl/tlb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB controller
// Sequences capture, execute and result hand-off.
// ----------------------------------------------------------------------------
module tlb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tlb_pkg::t_cmd o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} t_state;
    t_state r_state;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;
    assign o_cmd.load  = o_in_ready && i_in_valid;
    assign o_cmd.exec  = r_state == S_EXEC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_EXEC;
                S_EXEC: r_state <= S_OUT;
                S_OUT:  if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/tlb_fully_associative_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fully associative TLB with LRU replacement
// Lookup, insert, flush and clear with saturating statistics.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_axis  | in  | tdata {phys_page, virt_page}, tuser req_type
//  m_axis  | out | tdata {flush_drop..lookup counts, slot, evicted, found, hit}
//  apb     | in  | register 0 current_asid at address 0
//
// Each item goes through capture, execute and hold result; the result is held until taken.
// The execute cycle compares all entries in parallel and updates ranks.
// Input is not taken while a result waits. Reset is synchronous, no clearing pass.
module tlb_fully_associative_lru #(
    parameter int ENTRIES   = 16,
    parameter int VPN_BITS  = 36,
    parameter int PPN_BITS  = 28,
    parameter int ASID_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [((VPN_BITS + PPN_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
                                          // virt_page[35:0], phys_page[63:36]
    input  logic [1:0]    s_axis_tuser,   // req_type
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [((PPN_BITS + $clog2(ENTRIES) + 5 * tlb_pkg::STAT_BITS + 2 + 7) / 8)
                  * 8 - 1:0] m_axis_tdata,
                                          // hit, found_page, evicted, slot_used,
                                          // lookup, hit, eviction, flush, drop counts
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam int OUT_W    = $bits(m_axis_tdata);

    tlb_pkg::t_cmd cmd;
    logic [ASID_BITS-1:0] r_asid;
    logic hit, evicted;
    logic [PPN_BITS-1:0] found;
    logic [IDX_BITS-1:0] slot;
    logic [tlb_pkg::STAT_BITS-1:0] c0, c1, c2, c3, c4;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? 32'(r_asid) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_asid <= '0;
        else if (psel && penable && pwrite && paddr == 2'd0) r_asid <= pwdata[ASID_BITS-1:0];
    end

    tlb_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_axis_tvalid), .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd      (cmd)
    );

    tlb_datapath #(.ENTRIES(ENTRIES), .VPN_BITS(VPN_BITS), .PPN_BITS(PPN_BITS),
                   .ASID_BITS(ASID_BITS), .IDX_BITS(IDX_BITS), .CNT_BITS(CNT_BITS))
    u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_req(s_axis_tuser),
        .i_vpn(s_axis_tdata[VPN_BITS-1:0]), .i_ppn(s_axis_tdata[VPN_BITS +: PPN_BITS]),
        .i_asid(r_asid), .o_hit(hit), .o_found(found), .o_evicted(evicted),
        .o_slot(slot), .o_lookups(c0), .o_hits(c1), .o_evictions(c2),
        .o_flushes(c3), .o_drops(c4)
    );

    // pad up to whole bytes
    assign m_axis_tdata = OUT_W'({c4, c3, c2, c1, c0, slot, evicted, found, hit});
endmodule
